/* sv/assert_macros.svh */
// Assertion helpers shared by the downscaler modules.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define HADS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hads: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define HADS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hads: next-cycle check failed");

`endif

/* sv/hads_pkg.sv */
// ----------------------------------------------------------------------------
// hads_pkg
// Shared constants, queue word and configuration types of the horizontal
// area downscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package hads_pkg;

  localparam int MAX_ROW_PIXELS = 4096;
  localparam int COL_W          = $clog2(MAX_ROW_PIXELS);
  localparam int FRAC_W         = 16;
  localparam int SRC_W_W        = 13;
  localparam int DST_W_W        = 12;
  localparam int EDGE_W         = 28;
  localparam int INV_W          = 16;
  localparam int SUM_W          = 40;
  localparam int WGT_W          = FRAC_W + 1;
  localparam int CH_W           = 8;
  localparam int NUM_CH         = 4;
  localparam int PROD_W         = SUM_W + INV_W;
  localparam int FIFO_DEPTH     = 4;
  localparam int FIFO_AW        = $clog2(FIFO_DEPTH);
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 28;

  localparam logic [WGT_W-1:0] ONE_Q16  = WGT_W'(1) << FRAC_W;
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_ROW_PIXELS - 1);

  // What the back end does with one queued pixel.
  typedef enum logic [1:0] {
    KIND_ACCUM,
    KIND_EMIT,
    KIND_LAST
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH  = 2'd0,
    CFG_DST_WIDTH  = 2'd1,
    CFG_SCALE_STEP = 2'd2,
    CFG_INV_SCALE  = 2'd3
  } cfg_idx_t;

  typedef logic [NUM_CH-1:0][CH_W-1:0] pix_t;

  typedef struct packed {
    pix_t             px;
    logic [WGT_W-1:0] wgt;   // weight of the pixel in the output it closes
    kind_t            kind;
    logic             clr;   // first pixel of a row: start sums from zero
  } qword_t;

  typedef struct packed {
    logic [SRC_W_W-1:0] src_width;
    logic [DST_W_W-1:0] dst_width;
    logic [EDGE_W-1:0]  scale_step;
    logic [INV_W-1:0]   inv_scale;
  } cfg_t;

endpackage

`default_nettype wire

/* sv/hads_front.sv */
// ----------------------------------------------------------------------------
// hads_front
// Tracks column, next output edge and output count; classifies each pixel
// and pushes it with its weight into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module hads_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           accept,
  input  wire hads_pkg::pix_t px,
  input  wire hads_pkg::cfg_t cfg,
  output hads_pkg::qword_t    qword
);
  import hads_pkg::*;

  logic [COL_W-1:0]   col_r, col_nxt;
  logic [EDGE_W-1:0]  edge_r, edge_nxt;
  logic [DST_W_W-1:0] cnt_r, cnt_nxt;

  logic               row_start;
  logic [EDGE_W-1:0]  edge_cur;
  logic [DST_W_W-1:0] cnt_cur;
  logic [COL_W:0]     col_inc;
  logic               is_last;
  logic [EDGE_W-1:0]  pos_start;
  logic [EDGE_W:0]    pos_end;
  logic               can_emit;
  logic               crosses;
  logic [WGT_W-1:0]   split_wgt;
  logic [EDGE_W:0]    edge_sum;
  logic [EDGE_W-1:0]  edge_adv;

  always_comb begin
    row_start = (col_r == '0);
    edge_cur  = row_start ? cfg.scale_step : edge_r;
    cnt_cur   = row_start ? '0 : cnt_r;
    col_inc   = {1'b0, col_r} + (COL_W+1)'(1);
    is_last   = ((SRC_W_W)'(col_inc) >= cfg.src_width) || (col_r == COL_LAST);
    pos_start = EDGE_W'({col_r, {FRAC_W{1'b0}}});
    pos_end   = {1'b0, pos_start} + (EDGE_W+1)'(ONE_Q16);
    can_emit  = ({1'b0, cnt_cur} + (DST_W_W+1)'(1)) < {1'b0, cfg.dst_width};
    crosses   = can_emit && ({1'b0, edge_cur} <= pos_end);
    split_wgt = (edge_cur > pos_start) ? WGT_W'(edge_cur - pos_start) : '0;
    edge_sum  = {1'b0, edge_cur} + {1'b0, cfg.scale_step};
    edge_adv  = edge_sum[EDGE_W] ? {EDGE_W{1'b1}} : edge_sum[EDGE_W-1:0];
  end

  // Queue word for this pixel.
  always_comb begin
    qword.px  = px;
    qword.clr = row_start;
    priority if (is_last) begin
      qword.kind = KIND_LAST;
      qword.wgt  = ONE_Q16;
    end else if (crosses) begin
      qword.kind = KIND_EMIT;
      qword.wgt  = split_wgt;
    end else begin
      qword.kind = KIND_ACCUM;
      qword.wgt  = ONE_Q16;
    end
  end

  always_comb begin
    col_nxt  = col_r;
    edge_nxt = edge_r;
    cnt_nxt  = cnt_r;
    if (accept) begin
      priority if (is_last) begin
        col_nxt  = '0;
        edge_nxt = cfg.scale_step;
        cnt_nxt  = '0;
      end else if (crosses) begin
        col_nxt  = col_inc[COL_W-1:0];
        edge_nxt = edge_adv;
        cnt_nxt  = cnt_cur + DST_W_W'(1);
      end else begin
        col_nxt  = col_inc[COL_W-1:0];
        edge_nxt = edge_cur;
        cnt_nxt  = cnt_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      edge_r <= '0;
      cnt_r  <= '0;
    end else begin
      col_r  <= col_nxt;
      edge_r <= edge_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/hads_fifo.sv */
// ----------------------------------------------------------------------------
// hads_fifo
// Short queue of classified pixels between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module hads_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire hads_pkg::qword_t wdata,
  input  wire logic             pop,
  output hads_pkg::qword_t      rdata,
  output logic                  full,
  output logic                  empty
);
  import hads_pkg::*;
  `include "assert_macros.svh"

  qword_t             mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]   count_r, count_nxt;

  assign full  = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + FIFO_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + FIFO_AW'(1) : rd_ptr_r;
    count_nxt  = count_r + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `HADS_ASSERT_IMP(a_no_push_full, push, !full)
  `HADS_ASSERT_IMP(a_no_pop_empty, pop, !empty)

endmodule

`default_nettype wire

/* sv/hads_back.sv */
// ----------------------------------------------------------------------------
// hads_back
// Applies queued pixels to the channel sums, closes outputs, scales them by
// the inverse step and holds the result word for the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module hads_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_empty,
  input  wire hads_pkg::qword_t              q_word,
  output logic                               pop,
  input  wire logic [hads_pkg::INV_W-1:0]    inv_scale,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output hads_pkg::pix_t                     out_px,
  output logic                               out_row_end
);
  import hads_pkg::*;
  `include "assert_macros.svh"

  logic [SUM_W-1:0] sum_r   [NUM_CH];
  logic [SUM_W-1:0] sum_nxt [NUM_CH];
  logic [SUM_W-1:0] closed  [NUM_CH];
  logic [SUM_W-1:0] carry   [NUM_CH];

  logic             p_valid_r;
  logic [SUM_W-1:0] p_sum_r [NUM_CH];
  logic             p_end_r;

  logic             out_valid_r;
  pix_t             out_px_r;
  logic             out_end_r;

  logic             o_free;
  logic             p_free;
  logic             closes;
  pix_t             fin;

  assign o_free = !out_valid_r || !out_stall;
  assign p_free = !p_valid_r || o_free;
  assign closes = (q_word.kind != KIND_ACCUM);
  assign pop    = !q_empty && (!closes || p_free);

  // Per-channel weighted add and the leftover share for the next output.
  always_comb begin
    logic [SUM_W-1:0] base;
    logic [WGT_W-1:0] rest_w;
    for (int k = 0; k < NUM_CH; k++) begin
      base     = q_word.clr ? '0 : sum_r[k];
      rest_w   = ONE_Q16 - q_word.wgt;
      closed[k] = base + SUM_W'(q_word.wgt) * SUM_W'(q_word.px[k]);
      carry[k]  = SUM_W'(rest_w) * SUM_W'(q_word.px[k]);
      unique case (q_word.kind)
        KIND_ACCUM: sum_nxt[k] = closed[k];
        KIND_EMIT:  sum_nxt[k] = carry[k];
        KIND_LAST:  sum_nxt[k] = '0;
        default:    sum_nxt[k] = closed[k];
      endcase
    end
  end

  // Scale by the inverse step, drop 32 fraction bits, clamp to 255.
  always_comb begin
    logic [PROD_W-1:0] prod;
    for (int k = 0; k < NUM_CH; k++) begin
      prod   = p_sum_r[k] * PROD_W'(inv_scale);
      fin[k] = (|prod[PROD_W-1:32+CH_W]) ? {CH_W{1'b1}} : prod[32+CH_W-1:32];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      for (int k = 0; k < NUM_CH; k++) begin
        sum_r[k] <= sum_nxt[k];
      end
    end
    if (pop && closes) begin
      for (int k = 0; k < NUM_CH; k++) begin
        p_sum_r[k] <= closed[k];
      end
      p_end_r <= (q_word.kind == KIND_LAST);
    end
    if (o_free && p_valid_r) begin
      out_px_r  <= fin;
      out_end_r <= p_end_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop && closes) begin
        p_valid_r <= 1'b1;
      end else if (o_free) begin
        p_valid_r <= 1'b0;
      end
      if (o_free) begin
        out_valid_r <= p_valid_r;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_px      = out_px_r;
  assign out_row_end = out_end_r;

  `HADS_ASSERT_IMP(a_close_needs_room, pop && closes, p_free)
  `HADS_ASSERT_NXT(a_stage_holds, p_valid_r && !o_free, p_valid_r)

endmodule

`default_nettype wire

/* sv/horizontal_area_downscaler.sv */
// A pixel that closes an output passes through the queue, the scaling stage register and the output register.
// Throughput: 1 pixel per cycle unless the output stalls, set by the single accumulate step per cycle in the back end.
// Output stalls back up through a 4-word queue; the input stalls only once it is full.
// Reset: synchronous, active low; clears column, edge, count, queue and valid flags,
// and loads the registers with 640, 320, 2.0 (Q12.16) and 0.5 (Q0.16).
// ----------------------------------------------------------------------------
// horizontal_area_downscaler
// Shrinks RGBA rows by area averaging: a front end classifies each pixel,
// a queue decouples it from a back end that accumulates and scales.
// ----------------------------------------------------------------------------
`default_nettype none

module horizontal_area_downscaler (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration write port
  input  wire logic                              cfg_we,
  input  wire logic [hads_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [hads_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // source pixel words
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [hads_pkg::CH_W-1:0]         in_red_in,
  input  wire logic [hads_pkg::CH_W-1:0]         in_green_in,
  input  wire logic [hads_pkg::CH_W-1:0]         in_blue_in,
  input  wire logic [hads_pkg::CH_W-1:0]         in_alpha_in,
  // averaged output words
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [hads_pkg::CH_W-1:0]              out_red_out,
  output logic [hads_pkg::CH_W-1:0]              out_green_out,
  output logic [hads_pkg::CH_W-1:0]              out_blue_out,
  output logic [hads_pkg::CH_W-1:0]              out_alpha_out,
  output logic                                   out_row_end
);
  import hads_pkg::*;

  cfg_t   cfg_r;
  pix_t   in_px;
  pix_t   res_px;
  qword_t push_word;
  qword_t head_word;
  logic   accept;
  logic   q_full;
  logic   q_empty;
  logic   q_pop;

  // Register writes: software must write only while the pipe is drained; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_width  <= SRC_W_W'(640);
      cfg_r.dst_width  <= DST_W_W'(320);
      cfg_r.scale_step <= EDGE_W'(131072);
      cfg_r.inv_scale  <= INV_W'(32768);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SRC_WIDTH:  cfg_r.src_width  <= cfg_wdata[SRC_W_W-1:0];
        CFG_DST_WIDTH:  cfg_r.dst_width  <= cfg_wdata[DST_W_W-1:0];
        CFG_SCALE_STEP: cfg_r.scale_step <= cfg_wdata[EDGE_W-1:0];
        CFG_INV_SCALE:  cfg_r.inv_scale  <= cfg_wdata[INV_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold the source off only while the queue is full.
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Pack channels in RGBA order.
  assign in_px[0] = in_red_in;
  assign in_px[1] = in_green_in;
  assign in_px[2] = in_blue_in;
  assign in_px[3] = in_alpha_in;

  // Front: advance column and edge, tag each pixel as accumulate, close or row end.
  hads_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .accept(accept),
    .px    (in_px),
    .cfg   (cfg_r),
    .qword (push_word)
  );

  hads_fifo u_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (accept),
    .wdata(push_word),
    .pop  (q_pop),
    .rdata(head_word),
    .full (q_full),
    .empty(q_empty)
  );

  // Back: update sums, scale closed outputs, hold the result word.
  hads_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_word     (head_word),
    .pop        (q_pop),
    .inv_scale  (cfg_r.inv_scale),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_px     (res_px),
    .out_row_end(out_row_end)
  );

  assign out_red_out   = res_px[0];
  assign out_green_out = res_px[1];
  assign out_blue_out  = res_px[2];
  assign out_alpha_out = res_px[3];

endmodule

`default_nettype wire
